@@ hw/rtl/brq_pkg.sv @@
// Shared constants and types for the bounded ring queue with drop statistics.
package brq_pkg;

   localparam int CAPACITY_DEF  = 16;
   localparam int ELEM_BITS_DEF = 32;

   localparam int PAYLOAD_BITS = 32;
   localparam int DEPTH_BITS   = 5;
   localparam int TOTAL_BITS   = 32;
   localparam int STATUS_BITS  = 2;

   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_DEQUEUE = 1'b1;

   localparam logic [STATUS_BITS-1:0] STATUS_DONE    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_DROPPED = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY   = 2'd2;

   typedef struct packed {
      logic exec;
      logic capture;
   } ctl_cmd_type;

endpackage

@@ hw/rtl/brq_if.sv @@
// Request and response channel interfaces of the ring queue.
interface brq_req_if;
   logic                             valid;
   logic                             ready;
   logic                             cmd;
   logic [brq_pkg::PAYLOAD_BITS-1:0] payload_in;

   modport source (output valid, cmd, payload_in, input ready);
   modport sink   (input valid, cmd, payload_in, output ready);
endinterface

interface brq_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [brq_pkg::STATUS_BITS-1:0]  status;
   logic [brq_pkg::PAYLOAD_BITS-1:0] data_out;
   logic                             wake;
   logic [brq_pkg::DEPTH_BITS-1:0]   depth;
   logic [brq_pkg::TOTAL_BITS-1:0]   enq_count;
   logic [brq_pkg::TOTAL_BITS-1:0]   deq_count;
   logic [brq_pkg::TOTAL_BITS-1:0]   drop_count;

   modport source (output valid, status, data_out, wake, depth, enq_count,
                   deq_count, drop_count, input ready);
   modport sink   (input valid, status, data_out, wake, depth, enq_count,
                   deq_count, drop_count, output ready);
endinterface

@@ hw/rtl/brq_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module brq_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data_ff
);

   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

@@ hw/rtl/brq_ctrl.sv @@
// Controller state machine: request accept, read capture, response hold.
module brq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output brq_pkg::ctl_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CAPTURE,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready   = req_ready_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign cmd.exec    = req_valid & req_ready_ff;
   assign cmd.capture = (state_ff == ST_CAPTURE);

   always_comb begin
      state_in     = state_ff;
      req_ready_in = req_ready_ff;
      rsp_valid_in = rsp_valid_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in     = ST_CAPTURE;
               req_ready_in = 1'b0;
            end
         end
         ST_CAPTURE: begin
            state_in     = ST_RESP;
            rsp_valid_in = 1'b1;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b0;
               req_ready_in = 1'b1;
            end
         end
         default: begin
            state_in     = ST_IDLE;
            req_ready_in = 1'b1;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ hw/rtl/brq_dpath.sv @@
// Datapath: ring pointers, fill count, totals, entry store and result registers.
module brq_dpath #(
   parameter int CAPACITY  = brq_pkg::CAPACITY_DEF,
   parameter int ELEM_BITS = brq_pkg::ELEM_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  brq_pkg::ctl_cmd_type                cmd,
   input  logic                                op,
   input  logic [brq_pkg::PAYLOAD_BITS-1:0]    payload_in,
   output logic [brq_pkg::STATUS_BITS-1:0]     status,
   output logic [brq_pkg::PAYLOAD_BITS-1:0]    data_out,
   output logic                                wake,
   output logic [brq_pkg::DEPTH_BITS-1:0]      depth,
   output logic [brq_pkg::TOTAL_BITS-1:0]      enq_count,
   output logic [brq_pkg::TOTAL_BITS-1:0]      deq_count,
   output logic [brq_pkg::TOTAL_BITS-1:0]      drop_count
);

   localparam int IdxBits   = $clog2(CAPACITY);
   localparam int CntBits   = $clog2(CAPACITY + 1);
   localparam int StoreBits = (ELEM_BITS < brq_pkg::PAYLOAD_BITS) ?
                              ELEM_BITS : brq_pkg::PAYLOAD_BITS;
   localparam int TotBits   = brq_pkg::TOTAL_BITS;

   logic [IdxBits-1:0]              wr_idx_ff, wr_idx_in;
   logic [IdxBits-1:0]              rd_idx_ff, rd_idx_in;
   logic [CntBits-1:0]              fill_ff, fill_in;
   logic [TotBits-1:0]              enq_ff, enq_in;
   logic [TotBits-1:0]              drain_ff, drain_in;
   logic [TotBits-1:0]              drop_ff, drop_in;
   logic [brq_pkg::STATUS_BITS-1:0] status_ff, status_in;
   logic                            wake_ff, wake_in;
   logic                            deq_ok_ff, deq_ok_in;
   logic [brq_pkg::PAYLOAD_BITS-1:0] data_ff, data_in;
   logic                            full, empty, ram_we;
   logic [StoreBits-1:0]            rd_data;

   assign full  = (fill_ff == CntBits'(CAPACITY));
   assign empty = (fill_ff == '0);

   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      fill_in   = fill_ff;
      enq_in    = enq_ff;
      drain_in  = drain_ff;
      drop_in   = drop_ff;
      status_in = status_ff;
      wake_in   = wake_ff;
      deq_ok_in = deq_ok_ff;
      ram_we    = 1'b0;
      if (cmd.exec) begin
         status_in = brq_pkg::STATUS_DONE;
         wake_in   = 1'b0;
         deq_ok_in = 1'b0;
         if (op == brq_pkg::CMD_ENQUEUE) begin
            if (full) begin
               drop_in   = drop_ff + 1'b1;
               status_in = brq_pkg::STATUS_DROPPED;
            end else begin
               ram_we    = 1'b1;
               wake_in   = empty;
               wr_idx_in = wr_idx_ff + 1'b1;
               fill_in   = fill_ff + 1'b1;
               enq_in    = enq_ff + 1'b1;
            end
         end else begin
            if (empty) begin
               status_in = brq_pkg::STATUS_EMPTY;
            end else begin
               deq_ok_in = 1'b1;
               rd_idx_in = rd_idx_ff + 1'b1;
               fill_in   = fill_ff - 1'b1;
               drain_in  = drain_ff + 1'b1;
            end
         end
      end
   end

   always_comb begin
      data_in = data_ff;
      if (cmd.capture) begin
         data_in = deq_ok_ff ? brq_pkg::PAYLOAD_BITS'(rd_data) : '0;
      end
   end

   brq_ram #(
      .Width (StoreBits),
      .Depth (CAPACITY)
   ) u_store (
      .clock      (clock),
      .wr_en      (ram_we),
      .wr_addr    (wr_idx_ff),
      .wr_data    (payload_in[StoreBits-1:0]),
      .rd_addr    (rd_idx_ff),
      .rd_data_ff (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         fill_ff   <= '0;
         enq_ff    <= '0;
         drain_ff  <= '0;
         drop_ff   <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         fill_ff   <= fill_in;
         enq_ff    <= enq_in;
         drain_ff  <= drain_in;
         drop_ff   <= drop_in;
      end
      status_ff <= status_in;
      wake_ff   <= wake_in;
      deq_ok_ff <= deq_ok_in;
      data_ff   <= data_in;
   end

   assign status     = status_ff;
   assign data_out   = data_ff;
   assign wake       = wake_ff;
   assign depth      = brq_pkg::DEPTH_BITS'(fill_ff);
   assign enq_count  = enq_ff;
   assign deq_count  = drain_ff;
   assign drop_count = drop_ff;

endmodule

@@ hw/rtl/bounded_ring_queue_with_drop_stats.sv @@
// Top level of the bounded ring queue with drop-on-full and running totals.
//
//   channel   dir   handshake     payload
//   req_chan  in    valid/ready   cmd, payload_in
//   rsp_chan  out   valid/ready   status, data_out, wake, depth, three totals
//
// One request at a time: accept, capture the registered store read, then hold
// the response until taken. Synchronous active-high reset clears pointers,
// fill count and totals; the entry store is not cleared. A stalled response
// blocks the next request.
module bounded_ring_queue_with_drop_stats #(
   parameter int CAPACITY  = brq_pkg::CAPACITY_DEF,
   parameter int ELEM_BITS = brq_pkg::ELEM_BITS_DEF
) (
   input logic      clock,
   input logic      reset,
   brq_req_if.sink  req_chan,
   brq_rsp_if.source rsp_chan
);

   brq_pkg::ctl_cmd_type cmd;

   brq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   brq_dpath #(
      .CAPACITY  (CAPACITY),
      .ELEM_BITS (ELEM_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .op         (req_chan.cmd),
      .payload_in (req_chan.payload_in),
      .status     (rsp_chan.status),
      .data_out   (rsp_chan.data_out),
      .wake       (rsp_chan.wake),
      .depth      (rsp_chan.depth),
      .enq_count  (rsp_chan.enq_count),
      .deq_count  (rsp_chan.deq_count),
      .drop_count (rsp_chan.drop_count)
   );

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the bounded ring queue with drop-on-full statistics.
module testbench;

   localparam int RANDOM_ITEMS = 1100;
   localparam int DRAIN_CYCLES = 12;
   localparam int PTR_BITS     = $clog2(brq_pkg::CAPACITY_DEF);

   typedef struct packed {
      logic                             cmd;
      logic [brq_pkg::PAYLOAD_BITS-1:0] payload;
   } ring_req_type;

   typedef struct packed {
      logic [brq_pkg::STATUS_BITS-1:0]  status;
      logic [brq_pkg::PAYLOAD_BITS-1:0] data;
      logic                             wake;
      logic [brq_pkg::DEPTH_BITS-1:0]   depth;
      logic [brq_pkg::TOTAL_BITS-1:0]   enq_total;
      logic [brq_pkg::TOTAL_BITS-1:0]   drain_total;
      logic [brq_pkg::TOTAL_BITS-1:0]   drop_total;
   } ring_rsp_type;

   logic clock;
   logic reset;

   brq_req_if req_chan ();
   brq_rsp_if rsp_chan ();

   bounded_ring_queue_with_drop_stats DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   ring_req_type request_backlog[$];
   ring_rsp_type awaited_rsps[$];
   ring_req_type next_request;
   int           request_total;
   int           accepted_count;
   int           mismatch_count;
   logic         req_fired;

   // shadow copy of the queue
   logic [brq_pkg::PAYLOAD_BITS-1:0] shadow_store [brq_pkg::CAPACITY_DEF];
   logic [PTR_BITS-1:0]              shadow_wr;
   logic [PTR_BITS-1:0]              shadow_rd;
   logic [brq_pkg::DEPTH_BITS-1:0]   shadow_fill;
   logic [brq_pkg::TOTAL_BITS-1:0]   shadow_enq;
   logic [brq_pkg::TOTAL_BITS-1:0]   shadow_drain;
   logic [brq_pkg::TOTAL_BITS-1:0]   shadow_drop;

   int n_enq, n_deq, n_dropped, n_empty_deq, n_wake, n_full_hits;

   task automatic predict_ring_step(input ring_req_type r);
      ring_rsp_type e;
      e = '0;
      e.status = brq_pkg::STATUS_DONE;
      if (r.cmd == brq_pkg::CMD_ENQUEUE) begin
         n_enq++;
         if (shadow_fill == brq_pkg::CAPACITY_DEF) begin
            shadow_drop = shadow_drop + 1'b1;
            e.status = brq_pkg::STATUS_DROPPED;
            n_dropped++;
         end else begin
            e.wake = (shadow_fill == 0);
            if (e.wake) n_wake++;
            shadow_store[shadow_wr] = r.payload;
            shadow_wr = shadow_wr + 1'b1;
            shadow_fill = shadow_fill + 1'b1;
            shadow_enq = shadow_enq + 1'b1;
            if (shadow_fill == brq_pkg::CAPACITY_DEF) n_full_hits++;
         end
      end else begin
         n_deq++;
         if (shadow_fill == 0) begin
            e.status = brq_pkg::STATUS_EMPTY;
            n_empty_deq++;
         end else begin
            e.data = shadow_store[shadow_rd];
            shadow_rd = shadow_rd + 1'b1;
            shadow_fill = shadow_fill - 1'b1;
            shadow_drain = shadow_drain + 1'b1;
         end
      end
      e.depth = shadow_fill;
      e.enq_total = shadow_enq;
      e.drain_total = shadow_drain;
      e.drop_total = shadow_drop;
      awaited_rsps.push_back(e);
   endtask

   function automatic void check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s: expected %0h, got %0h", name, exp_val, act_val);
         mismatch_count++;
      end
   endfunction

   function automatic void add_request(logic cmd, logic [brq_pkg::PAYLOAD_BITS-1:0] payload);
      ring_req_type r;
      r.cmd = cmd;
      r.payload = payload;
      request_backlog.push_back(r);
   endfunction

   function automatic int sender_idle_pct();
      if (accepted_count < request_total / 3) return 12;
      if (accepted_count < 2 * request_total / 3) return 81;
      return 0;
   endfunction

   function automatic int receiver_stall_pct();
      if (accepted_count < request_total / 3) return 81;
      if (accepted_count < 2 * request_total / 3) return 12;
      return 0;
   endfunction

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.cmd = brq_pkg::CMD_ENQUEUE;
      req_chan.payload_in = '0;
      rsp_chan.ready = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   initial begin
      #1000000;
      $display("simulation failed");
      $finish;
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct());
         if (!req_chan.valid || req_fired) begin
            if (request_backlog.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
               next_request = request_backlog.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.cmd <= next_request.cmd;
               req_chan.payload_in <= next_request.payload;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // monitor and prediction
   always @(posedge clock) begin
      ring_rsp_type e;
      if (reset) begin
         req_fired <= 1'b0;
         shadow_wr = '0;
         shadow_rd = '0;
         shadow_fill = '0;
         shadow_enq = '0;
         shadow_drain = '0;
         shadow_drop = '0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (awaited_rsps.size() == 0) begin
               $error("response with no request outstanding");
               mismatch_count++;
            end else begin
               e = awaited_rsps.pop_front();
               check_field("status", 32'(e.status), 32'(rsp_chan.status));
               check_field("data_out", e.data, rsp_chan.data_out);
               check_field("wake", 32'(e.wake), 32'(rsp_chan.wake));
               check_field("depth", 32'(e.depth), 32'(rsp_chan.depth));
               check_field("enq_count", e.enq_total, rsp_chan.enq_count);
               check_field("deq_count", e.drain_total, rsp_chan.deq_count);
               check_field("drop_count", e.drop_total, rsp_chan.drop_count);
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            ring_req_type r;
            r.cmd = req_chan.cmd;
            r.payload = req_chan.payload_in;
            predict_ring_step(r);
            accepted_count++;
         end
         req_fired <= req_chan.valid && req_chan.ready;
      end
   end

   initial begin
      int burst_len;
      int enq_bias;
      logic [brq_pkg::PAYLOAD_BITS-1:0] pl;
      mismatch_count = 0;
      accepted_count = 0;
      n_enq = 0; n_deq = 0; n_dropped = 0; n_empty_deq = 0; n_wake = 0; n_full_hits = 0;

      // directed: empty dequeue, fill with extremes, drop on full, wrap
      add_request(brq_pkg::CMD_DEQUEUE, 32'hFFFF_FFFF);
      add_request(brq_pkg::CMD_ENQUEUE, 32'h0000_0000);
      add_request(brq_pkg::CMD_ENQUEUE, 32'hFFFF_FFFF);
      add_request(brq_pkg::CMD_ENQUEUE, 32'hAAAA_AAAA);
      add_request(brq_pkg::CMD_ENQUEUE, 32'h5555_5555);
      add_request(brq_pkg::CMD_ENQUEUE, 32'h8000_0000);
      add_request(brq_pkg::CMD_ENQUEUE, 32'h0000_0001);
      add_request(brq_pkg::CMD_ENQUEUE, 32'h7FFF_FFFF);
      add_request(brq_pkg::CMD_ENQUEUE, 32'hFFFF_FFFE);
      for (int i = 0; i < 8; i++) add_request(brq_pkg::CMD_ENQUEUE, $urandom);
      add_request(brq_pkg::CMD_ENQUEUE, 32'hFFFF_FFFF);
      add_request(brq_pkg::CMD_ENQUEUE, 32'h0000_0000);
      add_request(brq_pkg::CMD_DEQUEUE, 32'h0000_0000);
      add_request(brq_pkg::CMD_ENQUEUE, 32'h1234_5678);
      add_request(brq_pkg::CMD_DEQUEUE, 32'hFFFF_FFFF);

      // random bursts biased toward filling, balanced, or biased toward draining
      while (request_backlog.size() < RANDOM_ITEMS + 22) begin
         burst_len = $urandom_range(40, 4);
         case ($urandom_range(2))
            0: enq_bias = 85;
            1: enq_bias = 50;
            default: enq_bias = 15;
         endcase
         for (int i = 0; i < burst_len; i++) begin
            case ($urandom_range(7))
               0: pl = '0;
               1: pl = '1;
               default: pl = $urandom;
            endcase
            add_request(($urandom_range(99) < enq_bias) ?
                        brq_pkg::CMD_ENQUEUE : brq_pkg::CMD_DEQUEUE, pl);
         end
      end
      request_total = request_backlog.size();

      @(negedge reset);
      while (accepted_count < request_total) @(posedge clock);
      while (awaited_rsps.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests: %0d enqueues (%0d dropped, %0d wakes), %0d dequeues (%0d empty)",
               request_total, n_enq, n_dropped, n_wake, n_deq, n_empty_deq);
      $display("queue reached full %0d times", n_full_hits);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/brq_pkg.sv
hw/rtl/brq_if.sv
hw/rtl/brq_ram.sv
hw/rtl/brq_ctrl.sv
hw/rtl/brq_dpath.sv
hw/rtl/bounded_ring_queue_with_drop_stats.sv
tb/testbench.sv
